FILE: rtl/psrc_pkg.sv
package psrc_pkg;

    localparam int SEQ_W   = 31;
    localparam int ACK_W   = 32;
    localparam int FRAG_W  = 16;
    localparam int LEN_W   = 16;
    localparam int FSIZE_W = 15;
    localparam int CAP_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int VERDICT_W  = 3;

    typedef logic [VERDICT_W-1:0] t_verdict;

    localparam t_verdict VERDICT_DELIVER     = 3'd0;
    localparam t_verdict VERDICT_REASSEMBLED = 3'd1;
    localparam t_verdict VERDICT_STALE       = 3'd2;
    localparam t_verdict VERDICT_MISSED      = 3'd3;
    localparam t_verdict VERDICT_ILLEGAL     = 3'd4;
    localparam t_verdict VERDICT_PARTIAL     = 3'd5;
    localparam t_verdict VERDICT_OVERSIZE    = 3'd6;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAGMENT_SIZE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MESSAGE_CAPACITY = 2'd1;

    localparam logic [FSIZE_W-1:0] FRAGMENT_SIZE_RESET    = 15'd16284;
    localparam logic [CAP_W-1:0]   MESSAGE_CAPACITY_RESET = 16'd16384;

    typedef struct packed {
        logic                     fragmented;
        logic [SEQ_W-1:0]         seq;
        logic [ACK_W-1:0]         ack;
        logic signed [FRAG_W-1:0] frag_start;
        logic signed [FRAG_W-1:0] frag_length;
        logic [LEN_W-1:0]         avail;
    } t_hdr;

    typedef struct packed {
        t_verdict         verdict;
        logic [SEQ_W-1:0] lost_count;
        logic [LEN_W-1:0] assembled_length;
        logic [SEQ_W-1:0] packet_sequence;
    } t_result;

    typedef struct packed {
        logic we;
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

endpackage

FILE: rtl/psrc_in_stage.sv
module psrc_in_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  psrc_pkg::t_hdr i_hdr,
    input  logic          i_advance,
    output logic          o_valid,
    output psrc_pkg::t_hdr o_hdr
);
    import psrc_pkg::*;

    logic r_valid;
    t_hdr r_hdr;
    logic n_load;

    // the stage frees up in the same cycle that its item moves on
    assign o_stall = r_valid && !i_advance;
    assign n_load  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (n_load) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_load) begin
            r_hdr <= i_hdr;
        end
    end

    assign o_valid = r_valid;
    assign o_hdr   = r_hdr;

endmodule

FILE: rtl/psrc_eval.sv
module psrc_eval #(
    parameter int BUFFER_BYTES = 16384
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  psrc_pkg::t_cfg_wr i_cfg,
    input  logic              i_fire,
    input  psrc_pkg::t_hdr    i_hdr,
    output psrc_pkg::t_result o_result
);
    import psrc_pkg::*;

    localparam logic [LEN_W:0] BUF_LIMIT = (LEN_W+1)'(BUFFER_BYTES);

    logic [FSIZE_W-1:0] r_fragment_size;
    logic [CAP_W-1:0]   r_message_capacity;

    logic [SEQ_W-1:0] r_last_seq;
    logic [ACK_W-1:0] r_last_ack;
    logic [SEQ_W-1:0] r_asm_seq;
    logic [LEN_W-1:0] r_fill;

    logic [SEQ_W-1:0] n_last_seq;
    logic [ACK_W-1:0] n_last_ack;
    logic [SEQ_W-1:0] n_asm_seq;
    logic [LEN_W-1:0] n_fill;

    logic             w_stale;
    logic [LEN_W-1:0] w_fill_base;
    logic             w_missed;
    logic             w_illegal;
    logic [LEN_W:0]   w_sum;
    logic [LEN_W-1:0] w_new_fill;
    logic             w_full_frag;
    logic             w_oversize;
    t_verdict         w_verdict;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fragment_size    <= FRAGMENT_SIZE_RESET;
            r_message_capacity <= MESSAGE_CAPACITY_RESET;
        end else if (i_cfg.we) begin
            unique case (i_cfg.index)
                CFG_FRAGMENT_SIZE:    r_fragment_size    <= i_cfg.data[FSIZE_W-1:0];
                CFG_MESSAGE_CAPACITY: r_message_capacity <= i_cfg.data[CAP_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_stale     = i_hdr.seq <= r_last_seq;
    // a fragment of another sequence starts from an empty buffer
    assign w_fill_base = (i_hdr.seq != r_asm_seq) ? '0 : r_fill;
    assign w_missed    = {i_hdr.frag_start[FRAG_W-1], i_hdr.frag_start} !=
                         $signed({1'b0, w_fill_base});
    assign w_sum       = {1'b0, w_fill_base} + {1'b0, i_hdr.frag_length};
    assign w_illegal   = i_hdr.frag_length[FRAG_W-1] ||
                         (LEN_W'(i_hdr.frag_length) > i_hdr.avail) ||
                         (w_sum > BUF_LIMIT);
    assign w_new_fill  = w_sum[LEN_W-1:0];
    assign w_full_frag = LEN_W'(i_hdr.frag_length) == {1'b0, r_fragment_size};
    assign w_oversize  = w_new_fill > r_message_capacity;

    always_comb begin
        w_verdict  = VERDICT_DELIVER;
        n_last_seq = r_last_seq;
        n_last_ack = r_last_ack;
        n_asm_seq  = r_asm_seq;
        n_fill     = r_fill;
        if (w_stale) begin
            w_verdict = VERDICT_STALE;
        end else if (!i_hdr.fragmented) begin
            n_last_seq = i_hdr.seq;
            n_last_ack = i_hdr.ack;
        end else begin
            n_asm_seq = i_hdr.seq;
            n_fill    = w_fill_base;
            if (w_missed) begin
                w_verdict = VERDICT_MISSED;
            end else if (w_illegal) begin
                w_verdict = VERDICT_ILLEGAL;
            end else if (w_full_frag) begin
                w_verdict = VERDICT_PARTIAL;
                n_fill    = w_new_fill;
            end else if (w_oversize) begin
                w_verdict = VERDICT_OVERSIZE;
                n_fill    = w_new_fill;
            end else begin
                w_verdict  = VERDICT_REASSEMBLED;
                n_fill     = '0;
                n_last_seq = i_hdr.seq;
                n_last_ack = i_hdr.ack;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_seq <= '0;
            r_last_ack <= '0;
            r_asm_seq  <= '0;
            r_fill     <= '0;
        end else if (i_fire) begin
            r_last_seq <= n_last_seq;
            r_last_ack <= n_last_ack;
            r_asm_seq  <= n_asm_seq;
            r_fill     <= n_fill;
        end
    end

    assign o_result.verdict          = w_verdict;
    assign o_result.lost_count       = w_stale ? '0 : i_hdr.seq - r_last_seq - SEQ_W'(1);
    assign o_result.assembled_length = (w_verdict == VERDICT_REASSEMBLED) ? w_new_fill : '0;
    assign o_result.packet_sequence  = i_hdr.seq;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_fill} <= BUF_LIMIT)
        else $error("reassembly fill beyond buffer");

    a_reasm_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && w_verdict == VERDICT_REASSEMBLED |=> r_fill == '0)
        else $error("fill not cleared after reassembly");

    a_ack_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && (w_verdict == VERDICT_DELIVER || w_verdict == VERDICT_REASSEMBLED)
        |=> r_last_ack == $past(i_hdr.ack) && r_last_seq == $past(i_hdr.seq))
        else $error("delivery did not advance sequence and ack");

    a_stale_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && w_verdict == VERDICT_STALE |=> $stable(r_last_seq) && $stable(r_fill))
        else $error("stale item changed state");

endmodule

FILE: rtl/packet_sequence_and_reassembly_check_core.sv
// channel   | valid       | stall       | payload
// ----------+-------------+-------------+---------------------------------------------
// header in | i_in_valid  | o_in_stall  | i_raw_sequence i_ack_sequence i_frag_start
//           |             |             | i_frag_length i_payload_available
// verdict   | o_out_valid | i_out_stall | o_verdict o_lost_count o_assembled_length
//           |             |             | o_packet_sequence
// config    | i_cfg_we    | -           | i_cfg_index i_cfg_data
//
// one header per cycle while i_out_stall is low; via header and verdict registers
// the header register feeds the check logic, which updates sequence/fill state
// as the item moves into the verdict register, so back to back headers see it
// reset is synchronous: clears both valids, the sequence and fill state, and
// restores the register defaults; no clearing pass is needed
// a stalled verdict blocks the header register only once it is full
module packet_sequence_and_reassembly_check_core #(
    parameter int BUFFER_BYTES = 16384
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // header channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [31:0]                         i_raw_sequence,
    input  logic signed [psrc_pkg::ACK_W-1:0]   i_ack_sequence,
    input  logic signed [psrc_pkg::FRAG_W-1:0]  i_frag_start,
    input  logic signed [psrc_pkg::FRAG_W-1:0]  i_frag_length,
    input  logic [psrc_pkg::LEN_W-1:0]          i_payload_available,
    // verdict channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [psrc_pkg::VERDICT_W-1:0]      o_verdict,
    output logic [psrc_pkg::SEQ_W-1:0]          o_lost_count,
    output logic [psrc_pkg::LEN_W-1:0]          o_assembled_length,
    output logic [psrc_pkg::SEQ_W-1:0]          o_packet_sequence,
    // register writes
    input  logic                                i_cfg_we,
    input  logic [psrc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [psrc_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import psrc_pkg::*;

    t_hdr    w_hdr_in;
    t_hdr    w_hdr;
    logic    w_hdr_valid;
    logic    w_advance;
    logic    w_fire;
    t_result w_result;
    t_cfg_wr w_cfg;

    logic    r_out_valid;
    t_result r_out;

    // split the sequence word: top bit flags a fragment
    assign w_hdr_in.fragmented  = i_raw_sequence[31];
    assign w_hdr_in.seq         = i_raw_sequence[SEQ_W-1:0];
    assign w_hdr_in.ack         = i_ack_sequence;
    assign w_hdr_in.frag_start  = i_frag_start;
    assign w_hdr_in.frag_length = i_frag_length;
    assign w_hdr_in.avail       = i_payload_available;

    assign w_cfg.we    = i_cfg_we;
    assign w_cfg.index = i_cfg_index;
    assign w_cfg.data  = i_cfg_data;

    // verdict register can take a new item when empty or being drained
    assign w_advance = !r_out_valid || !i_out_stall;
    assign w_fire    = w_hdr_valid && w_advance;

    psrc_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_stall   (o_in_stall),
        .i_hdr     (w_hdr_in),
        .i_advance (w_advance),
        .o_valid   (w_hdr_valid),
        .o_hdr     (w_hdr)
    );

    psrc_eval #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_eval (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_fire   (w_fire),
        .i_hdr    (w_hdr),
        .o_result (w_result)
    );

    // verdict register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_hdr_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_verdict          = r_out.verdict;
    assign o_lost_count       = r_out.lost_count;
    assign o_assembled_length = r_out.assembled_length;
    assign o_packet_sequence  = r_out.packet_sequence;

endmodule

FILE: tb/tb_packet_sequence_and_reassembly_check_core.sv
`timescale 1ns / 100ps

module tb_packet_sequence_and_reassembly_check_core;

    import psrc_pkg::*;

    localparam int BUFFER_BYTES = 16384;
    // margin after the last verdict has come back
    localparam int DRAIN_CYCLES = 4;
    localparam int CLK_HALF_NS  = 6;
    // far beyond the slowest correct run
    localparam int TIMEOUT_NS   = 200000 * 2 * CLK_HALF_NS;

    // register index that decodes to nothing
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    // dut ports, inputs at known values from time zero
    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_in_valid = 1'b0;
    logic                        o_in_stall;
    logic [31:0]                 i_raw_sequence = '0;
    logic signed [ACK_W-1:0]     i_ack_sequence = '0;
    logic signed [FRAG_W-1:0]    i_frag_start = '0;
    logic signed [FRAG_W-1:0]    i_frag_length = '0;
    logic [LEN_W-1:0]            i_payload_available = '0;
    logic                        o_out_valid;
    logic                        i_out_stall = 1'b0;
    logic [VERDICT_W-1:0]        o_verdict;
    logic [SEQ_W-1:0]            o_lost_count;
    logic [LEN_W-1:0]            o_assembled_length;
    logic [SEQ_W-1:0]            o_packet_sequence;
    logic                        i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]        i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]       i_cfg_data = '0;

    // predictor copy of the receive state and the registers
    logic [SEQ_W-1:0]   seen_seq;
    logic [ACK_W-1:0]   seen_ack;
    logic [SEQ_W-1:0]   build_seq;
    int                 build_fill;
    logic [FSIZE_W-1:0] frag_size;
    logic [CAP_W-1:0]   capacity;

    // verdicts predicted at header acceptance, oldest first
    t_result pending_verdicts[$];
    t_result want;

    int mismatch_count = 0;
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    // cycles left in a forced receiver hold-off
    int hold_left = 0;

    packet_sequence_and_reassembly_check_core #(
        .BUFFER_BYTES(BUFFER_BYTES)
    ) i_dut (.*);

    always begin
        #CLK_HALF_NS i_clk = 1'b1;
        #CLK_HALF_NS i_clk = 1'b0;
    end

    initial begin
        #TIMEOUT_NS;
        $display("tb_packet_sequence_and_reassembly_check_core failed");
        $finish;
    end

    // one line per mismatch, counted for the final verdict
    task automatic report_mismatch(input string what, input longint got, input longint exp_v);
        $display("%0t: %s: got %0d expected %0d", $time, what, got, exp_v);
        mismatch_count++;
    endtask

    // advance the receive state by one header and return the verdict it causes
    function automatic t_result predict_verdict(input logic [31:0] raw,
                                                input logic [ACK_W-1:0] ack,
                                                input logic signed [FRAG_W-1:0] fstart,
                                                input logic signed [FRAG_W-1:0] flen,
                                                input logic [LEN_W-1:0] avail);
        t_result r;
        logic [SEQ_W-1:0] seq;
        int start_i;
        int len_i;
        seq = raw[30:0];
        start_i = fstart;
        len_i = flen;
        r.verdict = VERDICT_STALE;
        r.lost_count = '0;
        r.assembled_length = '0;
        r.packet_sequence = seq;
        if (seq > seen_seq) begin
            r.lost_count = seq - seen_seq - 1'b1;
            if (!raw[31]) begin
                r.verdict = VERDICT_DELIVER;
                seen_seq = seq;
                seen_ack = ack;
            end else begin
                // a new fragment sequence restarts assembly before any check
                if (seq != build_seq) begin
                    build_seq = seq;
                    build_fill = 0;
                end
                if (start_i != build_fill) begin
                    r.verdict = VERDICT_MISSED;
                end else if (len_i < 0 || len_i > int'(avail) ||
                             build_fill + len_i > BUFFER_BYTES) begin
                    r.verdict = VERDICT_ILLEGAL;
                end else begin
                    build_fill += len_i;
                    if (len_i == int'(frag_size)) begin
                        // full-size fragment: more to come
                        r.verdict = VERDICT_PARTIAL;
                    end else if (build_fill > int'(capacity)) begin
                        // fill kept, nothing delivered
                        r.verdict = VERDICT_OVERSIZE;
                    end else begin
                        r.verdict = VERDICT_REASSEMBLED;
                        r.assembled_length = 16'(build_fill);
                        build_fill = 0;
                        seen_seq = seq;
                        seen_ack = ack;
                    end
                end
            end
        end
        return r;
    endfunction

    // random idle before the item, then hold it until the block takes it
    task automatic send_header(input logic [31:0] raw, input logic [ACK_W-1:0] ack,
                               input logic [FRAG_W-1:0] fstart, input logic [FRAG_W-1:0] flen,
                               input logic [LEN_W-1:0] avail);
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_raw_sequence <= raw;
        i_ack_sequence <= ack;
        i_frag_start <= fstart;
        i_frag_length <= flen;
        i_payload_available <= avail;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_verdicts.push_back(predict_verdict(raw, ack, fstart, flen, avail));
    endtask

    task automatic send_plain(input logic [SEQ_W-1:0] seq);
        send_header({1'b0, seq}, $urandom, 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic send_fragment(input logic [SEQ_W-1:0] seq, input int start,
                                 input int len, input int avail);
        send_header({1'b1, seq}, $urandom, 16'(start), 16'(len), 16'(avail));
    endtask

    // sender stops and waits until every predicted verdict has come back
    task automatic wait_for_verdicts();
        i_in_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // registers change only with the block idle
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        wait_for_verdicts();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_FRAGMENT_SIZE:    frag_size = data[FSIZE_W-1:0];
            CFG_MESSAGE_CAPACITY: capacity = data;
            default: ;
        endcase
    endtask

    // next fresh sequence: mostly small steps, now and then a wide gap
    function automatic logic [SEQ_W-1:0] next_sequence();
        if ($urandom_range(99) < 3)
            return seen_seq + SEQ_W'($urandom_range(1, 1 << 20));
        return seen_seq + 1'b1 + SEQ_W'($urandom_range(0, 3));
    endfunction

    // mostly well-formed fragment trains, some plain, stale and garbage headers
    task automatic send_random_header();
        int pick;
        int start;
        int len;
        int room;
        int avail;
        logic [SEQ_W-1:0] seq;
        pick = $urandom_range(99);
        if (pick < 8) begin
            seq = SEQ_W'($urandom_range(0, seen_seq));
            send_header({1'($urandom_range(1)), seq}, $urandom, 16'($urandom),
                        16'($urandom), 16'($urandom));
        end else if (pick < 28) begin
            send_plain(next_sequence());
        end else if (pick < 88) begin
            // continue the open message or start a new one
            if (build_seq > seen_seq && build_fill != 0 && $urandom_range(9) != 0) begin
                seq = build_seq;
                start = build_fill;
            end else begin
                seq = next_sequence();
                start = 0;
            end
            room = BUFFER_BYTES - start;
            if ($urandom_range(2) != 0 && int'(frag_size) <= room)
                len = frag_size;
            else begin
                len = $urandom_range(0, 40);
                if (len > room)
                    len = room;
            end
            avail = ($urandom_range(7) == 0) ? $urandom_range(0, 16'hFFFF)
                                             : len + $urandom_range(0, 64);
            // occasional broken fragment inside a good train
            case ($urandom_range(19))
                0: start = start + $urandom_range(1, 3);
                1: len = -len - 1;
                2: avail = (len > 0) ? len - 1 : avail;
                default: ;
            endcase
            send_fragment(seq, start, len, avail);
        end else begin
            seq = ($urandom_range(3) == 0 && build_seq > seen_seq) ? build_seq : next_sequence();
            send_header({1'b1, seq}, $urandom, 16'($urandom), 16'($urandom), 16'($urandom));
        end
    endtask

    // receiver: random stalls, or a counted hold-off when one is requested
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    // compare each accepted verdict with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_verdicts.size() == 0) begin
                report_mismatch("verdict with nothing pending", o_verdict, -1);
            end else begin
                want = pending_verdicts.pop_front();
                if (o_verdict !== want.verdict)
                    report_mismatch("verdict", o_verdict, want.verdict);
                if (o_lost_count !== want.lost_count)
                    report_mismatch("lost_count", o_lost_count, want.lost_count);
                if (o_assembled_length !== want.assembled_length)
                    report_mismatch("assembled_length", o_assembled_length,
                                    want.assembled_length);
                if (o_packet_sequence !== want.packet_sequence)
                    report_mismatch("packet_sequence", o_packet_sequence,
                                    want.packet_sequence);
            end
        end
    end

    task automatic test_random_traffic(input int count);
        repeat (count) send_random_header();
    endtask

    // plain delivery, lost-packet gap, extreme acks
    task automatic test_delivery_and_gaps();
        send_header(32'd1, 32'h8000_0000, 16'd0, 16'd0, 16'd0);
        send_header(32'd5, 32'h7FFF_FFFF, 16'd0, 16'd0, 16'hFFFF);
    endtask

    // repeated and older sequences are dropped, fragmented or not
    task automatic test_stale();
        send_plain(31'd5);
        send_plain(31'd0);
        send_fragment(31'd5, 0, 1, 1);
    endtask

    // frag fields are not looked at on an unfragmented packet
    task automatic test_ignored_fragment_fields();
        send_header(32'd6, $urandom, 16'h8000, 16'h8000, 16'h0000);
        send_header(32'd7, $urandom, 16'h7FFF, 16'h7FFF, 16'hFFFF);
    endtask

    // full fragment held, short one completes; buffer filled exactly; empty message
    task automatic test_reassembly();
        send_fragment(31'd8, 0, 16284, 16284);
        send_fragment(31'd8, 16284, 100, 100);
        send_fragment(31'd9, 0, 0, 0);
    endtask

    // offset mismatch keeps the fill; a new sequence restarts it
    task automatic test_missed_fragment();
        send_fragment(31'd10, 0, 16284, 16284);
        send_fragment(31'd10, 16000, 5, 5);
        send_fragment(31'd10, -1, 5, 5);
        send_fragment(31'd10, 16284, 5, 5);
        send_fragment(31'd12, 0, 16284, 20000);
        send_fragment(31'd13, 16284, 5, 5);
    endtask

    // negative length, length past payload, fill past buffer
    task automatic test_illegal_length();
        send_fragment(31'd14, 0, -1, 100);
        send_fragment(31'd14, 0, 10, 9);
        send_fragment(31'd14, 0, 16284, 16'hFFFF);
        send_fragment(31'd14, 16284, 101, 200);
        send_fragment(31'd14, 16284, 100, 100);
        send_fragment(31'd15, 0, 16'h7FFF, 16'hFFFF);
    endtask

    // completed message above capacity, then one exactly at capacity
    task automatic test_oversize();
        logic [SEQ_W-1:0] s;
        write_register(CFG_MESSAGE_CAPACITY, 16'd100);
        write_register(CFG_FRAGMENT_SIZE, 16'd64);
        s = seen_seq + 1'b1;
        send_fragment(s, 0, 64, 64);
        send_fragment(s, 64, 50, 50);
        send_fragment(s, 114, 10, 60);
        send_fragment(s + 1'b1, 0, 64, 64);
        send_fragment(s + 1'b1, 64, 36, 36);
        test_random_traffic(20);
    endtask

    // register extremes, zero fragment size, masked high bit, unused index
    task automatic test_register_extremes();
        logic [SEQ_W-1:0] s;
        write_register(CFG_FRAGMENT_SIZE, 16'd0);
        write_register(CFG_MESSAGE_CAPACITY, 16'hFFFF);
        // zero-length fragments count as full while the size is zero
        s = seen_seq + 1'b1;
        send_fragment(s, 0, 0, 0);
        send_fragment(s, 0, 0, 7);
        send_fragment(s, 0, 5, 5);
        test_random_traffic(25);

        // bit 15 of the data falls outside the 15-bit register
        write_register(CFG_FRAGMENT_SIZE, 16'hFFFF);
        write_register(CFG_MESSAGE_CAPACITY, 16'd0);
        s = seen_seq + 1'b1;
        send_fragment(s, 0, 0, 0);
        send_fragment(s + 1'b1, 0, 1, 1);
        test_random_traffic(25);

        write_register(CFG_FRAGMENT_SIZE, 16'd1);
        write_register(CFG_MESSAGE_CAPACITY, 16'hFFFF);
        test_random_traffic(25);

        write_register(CFG_UNUSED_INDEX, 16'($urandom));
        test_random_traffic(15);
    endtask

    // long receiver hold-off with the sender pushing, then a full drain
    task automatic test_backpressure();
        @(negedge i_clk);
        hold_left = 80;
        @(posedge i_clk);
        test_random_traffic(16);
        wait_for_verdicts();
    endtask

    // wide gaps up to the top sequence; everything after it is stale
    task automatic test_sequence_limit();
        send_plain(31'h2AAA_AAAA);
        send_fragment(31'h5555_5555, 0, 0, 0);
        send_plain(31'h7FFF_FFFF);
        send_header(32'hFFFF_FFFF, $urandom, 16'($urandom), 16'($urandom), 16'($urandom));
        repeat (10)
            send_header($urandom, $urandom, 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    initial begin
        seen_seq = '0;
        seen_ack = '0;
        build_seq = '0;
        build_fill = 0;
        frag_size = FRAGMENT_SIZE_RESET;
        capacity = MESSAGE_CAPACITY_RESET;

        // single synchronous reset at the start
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // sender idles lightly, receiver heavily; register defaults
        sender_idle_pct = 34;
        receiver_stall_pct = 64;
        test_delivery_and_gaps();
        test_stale();
        test_ignored_fragment_fields();
        test_reassembly();
        test_missed_fragment();
        test_illegal_length();
        test_random_traffic(140);

        // roles swapped
        sender_idle_pct = 64;
        receiver_stall_pct = 34;
        test_oversize();
        test_register_extremes();
        write_register(CFG_FRAGMENT_SIZE, 16'd48);
        write_register(CFG_MESSAGE_CAPACITY, 16'd300);
        test_random_traffic(180);

        // no idling at all
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        write_register(CFG_FRAGMENT_SIZE, 16'd100);
        write_register(CFG_MESSAGE_CAPACITY, 16'd1500);
        test_backpressure();
        test_random_traffic(220);
        test_sequence_limit();

        wait_for_verdicts();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && pending_verdicts.size() == 0) begin
            $display("tb_packet_sequence_and_reassembly_check_core passed");
        end else begin
            $display("tb_packet_sequence_and_reassembly_check_core failed");
        end
        $finish;
    end

endmodule
